// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

// ===== hw/rtl/id3p_pkg.sv =====
// Package with types, codes and the ID upgrade table of the ID3v2 frame parser.
package id3p_pkg;
    localparam int unsigned TableLen = 50;

    typedef enum logic [3:0] {
        ST_OK = 4'd0, ST_ENCRYPTED = 4'd1, ST_COMPRESSED = 4'd2, ST_SKIPPED = 4'd3,
        ST_PADDING = 4'd4, ST_TAG_END = 4'd5, ST_ERR_SYNCSAFE = 4'd6,
        ST_ERR_VERSION = 4'd7, ST_ERR_TAG_FLAGS = 4'd8, ST_ERR_EXT_HDR = 4'd9,
        ST_ERR_FHDR_TRUNC = 4'd10, ST_ERR_FRAME_TRUNC = 4'd11,
        ST_ERR_FRAME_FLAGS = 4'd12, ST_ERR_FOOTER = 4'd13, ST_ERR_SOURCE_END = 4'd14
    } t_status;

    // Input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       source_end;
    } t_in_item;

    // Result item (frame ID, payload offset and payload length at full 32-bit width).
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] frame_id;
        logic [15:0] frame_flags;
        logic [31:0] payload_offset;
        logic [31:0] payload_length;
        logic [7:0]  tag_version;
    } t_out_item;

    // One upgrade table entry: three-letter v2.2 ID and four-letter v2.3 ID.
    typedef struct packed {
        logic [23:0] old_id;
        logic [31:0] new_id;
    } t_upgrade;

    function automatic t_upgrade upgrade_entry(input logic [5:0] idx);
        t_upgrade e;
        e = '0;
        unique case (idx)
            6'd0:  e = {"BUF", "RBUF"};
            6'd1:  e = {"CNT", "PCNT"};
            6'd2:  e = {"COM", "COMM"};
            6'd3:  e = {"ETC", "ETCO"};
            6'd4:  e = {"GEO", "GEOB"};
            6'd5:  e = {"MLL", "MLLT"};
            6'd6:  e = {"POP", "POPM"};
            6'd7:  e = {"REV", "RVRB"};
            6'd8:  e = {"SLT", "SYLT"};
            6'd9:  e = {"STC", "SYTC"};
            6'd10: e = {"TAL", "TALB"};
            6'd11: e = {"TBP", "TBPM"};
            6'd12: e = {"TCM", "TCOM"};
            6'd13: e = {"TCO", "TCON"};
            6'd14: e = {"TCR", "TCOP"};
            6'd15: e = {"TDY", "TDLY"};
            6'd16: e = {"TEN", "TENC"};
            6'd17: e = {"TFT", "TFLT"};
            6'd18: e = {"TKE", "TKEY"};
            6'd19: e = {"TLA", "TLAN"};
            6'd20: e = {"TLE", "TLEN"};
            6'd21: e = {"TMT", "TMED"};
            6'd22: e = {"TOA", "TOPE"};
            6'd23: e = {"TOF", "TOFN"};
            6'd24: e = {"TOL", "TOLY"};
            6'd25: e = {"TOT", "TOAL"};
            6'd26: e = {"TP1", "TPE1"};
            6'd27: e = {"TP2", "TPE2"};
            6'd28: e = {"TP3", "TPE3"};
            6'd29: e = {"TP4", "TPE4"};
            6'd30: e = {"TPA", "TPOS"};
            6'd31: e = {"TPB", "TPUB"};
            6'd32: e = {"TRC", "TSRC"};
            6'd33: e = {"TRK", "TRCK"};
            6'd34: e = {"TSI", "TSIZ"};
            6'd35: e = {"TSS", "TSSE"};
            6'd36: e = {"TT1", "TIT1"};
            6'd37: e = {"TT2", "TIT2"};
            6'd38: e = {"TT3", "TIT3"};
            6'd39: e = {"TXT", "TEXT"};
            6'd40: e = {"TXX", "TXXX"};
            6'd41: e = {"UFI", "UFID"};
            6'd42: e = {"ULT", "USLT"};
            6'd43: e = {"WAF", "WOAF"};
            6'd44: e = {"WAR", "WOAR"};
            6'd45: e = {"WAS", "WOAS"};
            6'd46: e = {"WCM", "WCOM"};
            6'd47: e = {"WCP", "WCOP"};
            6'd48: e = {"WPB", "WPUB"};
            6'd49: e = {"WXX", "WXXX"};
            default: e = '0;
        endcase
        return e;
    endfunction
endpackage

// ===== hw/rtl/id3p_stream_if.sv =====
// Valid/ready stream interface carrying one payload word.
interface id3p_stream_if #(parameter type T = logic [7:0]);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/id3v2_frame_parser.sv =====
// Top level of the ID3v2 tag frame parser.
// Channel | Dir | Payload
// in_ch   | in  | data_byte[8], first_byte, source_end
// out_ch  | out | status[4], frame_id[32], frame_flags[16], payload_offset, payload_length,
//         |     | tag_version[8]
// One byte is accepted each cycle while the queue is not full; the walker updates its counters in that cycle.
// Results pass a four-entry queue and then an output register.
// Input ready drops only while the queue is full; the output side may stall freely.
// Synchronous active-low reset returns the walker to idle and empties the queue.
module id3v2_frame_parser #(
    parameter int unsigned LENGTH_WIDTH    = 32,
    parameter int unsigned UPGRADE_ENTRIES = 50
) (
    input  logic i_clk,
    input  logic i_rst_n,
    id3p_stream_if.sink   in_ch,
    id3p_stream_if.source out_ch
);
    localparam int unsigned QW = $bits(id3p_pkg::t_out_item);

    logic push, full, pop, empty;
    id3p_pkg::t_out_item f_res, q_res;
    logic [QW-1:0] q_raw;
    logic [3:0]  b_status;
    logic [31:0] b_frame_id;
    logic [15:0] b_frame_flags;
    logic [31:0] b_offset;
    logic [31:0] b_length;
    logic [7:0]  b_version;

    id3p_front #(.LENGTH_WIDTH(LENGTH_WIDTH), .UPGRADE_ENTRIES(UPGRADE_ENTRIES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_ch.valid), .i_item(in_ch.payload),
        .o_ready(in_ch.ready), .o_push(push), .o_result(f_res), .i_full(full)
    );

    id3p_fifo #(.WIDTH(QW), .DEPTH(4)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(f_res), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_data(q_raw)
    );
    assign q_res = q_raw;

    id3p_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_item(q_res), .o_pop(pop),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_status(b_status), .o_frame_id(b_frame_id),
        .o_frame_flags(b_frame_flags),
        .o_payload_offset(b_offset),
        .o_payload_length(b_length),
        .o_tag_version(b_version)
    );

    // Output payload assembled in one place.
    assign out_ch.payload = '{status: b_status, frame_id: b_frame_id,
                              frame_flags: b_frame_flags, payload_offset: b_offset,
                              payload_length: b_length, tag_version: b_version};
endmodule

// ===== hw/rtl/id3p_fifo.sv =====
// Short register queue between the parser front and the result back end.
module id3p_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== hw/rtl/id3p_front.sv =====
// Byte classifier and tag walker: one byte per cycle while the queue is not full, pushes results to the queue.
module id3p_front #(
    parameter int unsigned LENGTH_WIDTH    = 32,
    parameter int unsigned UPGRADE_ENTRIES = 50
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  id3p_pkg::t_in_item   i_item,
    output logic                 o_ready,
    output logic                 o_push,
    output id3p_pkg::t_out_item  o_result,
    input  logic                 i_full
);
    typedef enum logic [2:0] {
        PH_IDLE, PH_HDR, PH_EXTLEN, PH_EXTSKIP, PH_FHDR, PH_FBODY, PH_PAD, PH_FOOT
    } t_phase;

    localparam logic [LENGTH_WIDTH-1:0] LenMask = '1;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_hcount, n_hcount;
    logic [7:0]  r_hdr [10];
    logic [7:0]  r_version, n_version;
    logic [27:0] r_tag_left, n_tag_left;
    logic [31:0] r_fleft, n_fleft;
    logic [31:0] r_pcount, n_pcount;
    logic [31:0] r_bpos, n_bpos;
    logic        r_prev_ff, n_prev_ff;
    logic        r_footer, n_footer;
    logic        r_unsync, n_unsync;
    logic [2:0]  r_extras, n_extras;
    logic        r_funsync, n_funsync;
    logic        r_fprev_ff, n_fprev_ff;
    logic [3:0]  r_fstatus, n_fstatus;
    logic [31:0] r_id, n_id;
    logic [15:0] r_flags, n_flags;
    logic [31:0] r_payoff, n_payoff;

    logic        take;
    logic        wr_en;
    logic [3:0]  wr_idx;
    logic        emit;
    id3p_pkg::t_out_item res;

    logic [7:0]  b;
    logic [7:0]  h [10];
    logic [31:0] up_id;

    assign o_ready = !i_full;
    assign take    = i_valid && o_ready;
    assign b       = i_item.data_byte;

    // Header view including the byte arriving now.
    always_comb begin
        for (int i = 0; i < 10; i++) h[i] = r_hdr[i];
        if (wr_en) h[wr_idx] = b;
    end

    // v2.2 ID upgrade search over the constant table, for the ID in r_hdr[0..2] or
    // the byte arriving now; entries are independent compares.
    always_comb begin
        up_id  = {8'h20, h[0], h[1], h[2]};
        for (int i = UPGRADE_ENTRIES - 1; i >= 0; i--) begin
            if (i < int'(id3p_pkg::TableLen)) begin
                if (id3p_pkg::upgrade_entry(6'(i)).old_id == {h[0], h[1], h[2]}) begin
                    up_id  = id3p_pkg::upgrade_entry(6'(i)).new_id;
                end
            end
        end
    end

    // Main next-state logic following the byte handling of the tag walker.
    always_comb begin
        logic [31:0] tl, len, skip, fl, pos;
        logic [7:0]  mask;
        logic [2:0]  extras;
        logic [3:0]  st, hc;
        logic        fun, fail_now, kept, fin, have;
        logic [3:0]  fcode;
        logic [27:0] tl_dec;

        n_phase = r_phase; n_hcount = r_hcount; n_version = r_version;
        n_tag_left = r_tag_left; n_fleft = r_fleft;
        n_pcount = r_pcount; n_bpos = r_bpos; n_prev_ff = r_prev_ff;
        n_footer = r_footer; n_unsync = r_unsync; n_extras = r_extras;
        n_funsync = r_funsync; n_fprev_ff = r_fprev_ff; n_fstatus = r_fstatus;
        n_id = r_id; n_flags = r_flags; n_payoff = r_payoff;
        wr_en = 1'b0; wr_idx = '0; emit = 1'b0; res = '0;
        fail_now = 1'b0; fcode = '0;
        tl = '0; len = '0; skip = '0; fl = '0; pos = '0; mask = '0; extras = '0;
        st = '0; hc = '0; fun = 1'b0; kept = 1'b0; fin = 1'b0; have = 1'b0;
        tl_dec = '0;

        if (take) begin
            if (i_item.first_byte) begin
                wr_en = 1'b1; wr_idx = 4'd0;
                n_hcount = 4'd1; n_phase = PH_HDR;
            end else if (r_phase == PH_HDR) begin
                wr_en = 1'b1; wr_idx = r_hcount;
                n_hcount = r_hcount + 4'd1;
                if (r_hcount == 4'd9) begin
                    // Tag header complete.
                    n_version = h[3];
                    n_bpos = '0; n_prev_ff = 1'b0;
                    tl = {4'd0, h[6][6:0], h[7][6:0], h[8][6:0], h[9][6:0]};
                    mask = (h[3] == 8'd2) ? 8'h7f : ((h[3] == 8'd3) ? 8'h3f : 8'h2f);
                    if (((h[6] | h[7] | h[8] | h[9]) & 8'h80) != 0) begin
                        fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_SYNCSAFE;
                    end else if (h[3] < 8'd2 || h[3] > 8'd4) begin
                        fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_VERSION;
                    end else if ((h[5] & mask) != 0) begin
                        fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_TAG_FLAGS;
                    end else begin
                        n_unsync = (h[3] < 8'd4) && h[5][7];
                        n_footer = 1'b0;
                        if (h[3] == 8'd4 && h[5][4]) begin
                            if (tl < 32'd10) begin
                                fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_FOOTER;
                            end else begin
                                tl = tl - 32'd10;
                                n_footer = 1'b1;
                            end
                        end
                        if (!fail_now) begin
                            n_tag_left = tl[27:0];
                            n_hcount = '0;
                            n_phase = (h[3] >= 8'd3 && h[5][6]) ? PH_EXTLEN : PH_FHDR;
                            if (tl == 0) begin
                                fin = 1'b1;
                            end
                        end
                    end
                end
            end else if (r_phase == PH_FOOT) begin
                if (r_hcount < 4'd3 && b != ((r_hcount == 4'd0) ? 8'h33 :
                        ((r_hcount == 4'd1) ? 8'h44 : 8'h49))) begin
                    fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_FOOTER;
                end else begin
                    n_hcount = r_hcount + 4'd1;
                    if (r_hcount == 4'd9) begin
                        n_phase = PH_IDLE;
                        emit = 1'b1;
                        res.status = id3p_pkg::ST_TAG_END;
                        res.payload_offset = r_bpos;
                    end
                end
            end else if (r_phase != PH_IDLE) begin
                // Body byte.
                tl_dec = r_tag_left - 28'd1;
                n_tag_left = tl_dec;
                if (r_unsync && r_prev_ff && b == 8'h00) begin
                    n_prev_ff = 1'b0;
                end else begin
                    kept = 1'b1;
                    pos = r_bpos;
                    if (r_unsync) n_prev_ff = (b == 8'hff);
                    n_bpos = (r_bpos + 32'd1) & 32'(LenMask);
                end
                if (kept) begin
                    unique case (r_phase)
                        PH_EXTLEN: begin
                            if (r_hcount < 4'd4) begin
                                wr_en = 1'b1; wr_idx = r_hcount;
                            end
                            n_hcount = r_hcount + 4'd1;
                            if (r_hcount == 4'd3) begin
                                if (r_version == 8'd4) begin
                                    skip = {4'd0, h[0][6:0], h[1][6:0], h[2][6:0], h[3][6:0]};
                                end else begin
                                    skip = {h[0], h[1], h[2], h[3]};
                                end
                                if (r_version == 8'd4 &&
                                        ((h[0] | h[1] | h[2] | h[3]) & 8'h80) != 0) begin
                                    fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_SYNCSAFE;
                                end else if (r_version == 8'd4 && skip < 32'd4) begin
                                    fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_EXT_HDR;
                                end else begin
                                    if (r_version == 8'd4) skip = skip - 32'd4;
                                    if (skip > {4'd0, tl_dec}) begin
                                        fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_EXT_HDR;
                                    end else begin
                                        n_hcount = '0;
                                        n_fleft = skip & 32'(LenMask);
                                        n_phase = (skip == 0) ? PH_FHDR : PH_EXTSKIP;
                                    end
                                end
                            end
                        end
                        PH_EXTSKIP: begin
                            n_fleft = (r_fleft - 32'd1) & 32'(LenMask);
                            if (n_fleft == 0) begin
                                n_phase = PH_FHDR; n_hcount = '0;
                            end
                        end
                        PH_FHDR: begin
                            if (r_hcount == 4'd0 && b == 8'h00) begin
                                n_phase = PH_PAD;
                                emit = 1'b1;
                                res.status = id3p_pkg::ST_PADDING;
                                res.payload_offset = pos;
                            end else begin
                                wr_en = 1'b1; wr_idx = r_hcount;
                                hc = r_hcount + 4'd1;
                                n_hcount = hc;
                                if (hc == ((r_version == 8'd2) ? 4'd6 : 4'd10)) begin
                                    fl = '0; extras = '0; st = id3p_pkg::ST_OK; fun = 1'b0;
                                    if (r_version == 8'd2) begin
                                        n_id = up_id;
                                        len = {8'd0, h[3], h[4], h[5]};
                                    end else begin
                                        n_id = {h[0], h[1], h[2], h[3]};
                                        fl = {16'd0, h[8], h[9]};
                                        if (r_version == 8'd4) begin
                                            len = {4'd0, h[4][6:0], h[5][6:0],
                                                   h[6][6:0], h[7][6:0]};
                                        end else begin
                                            len = {h[4], h[5], h[6], h[7]};
                                        end
                                    end
                                    if (r_version == 8'd4 &&
                                            ((h[4] | h[5] | h[6] | h[7]) & 8'h80) != 0) begin
                                        fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_SYNCSAFE;
                                    end else if (len > {4'd0, tl_dec}) begin
                                        fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_FRAME_TRUNC;
                                    end else if (r_version == 8'd3 && (fl & 32'h1f) != 0) begin
                                        fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_FRAME_FLAGS;
                                    end else begin
                                        if (r_version == 8'd3) begin
                                            extras = {2'd0, fl[5]};
                                            st = fl[6] ? id3p_pkg::ST_ENCRYPTED :
                                                (fl[7] ? id3p_pkg::ST_COMPRESSED :
                                                 id3p_pkg::ST_OK);
                                        end else if (r_version == 8'd4) begin
                                            if ((fl & 32'h80b0) != 0) begin
                                                st = id3p_pkg::ST_SKIPPED;
                                            end else begin
                                                extras = (fl[0] ? 3'd4 : 3'd0) +
                                                         (fl[6] ? 3'd1 : 3'd0);
                                                fun = fl[1];
                                                st = fl[2] ? id3p_pkg::ST_ENCRYPTED :
                                                    (fl[3] ? id3p_pkg::ST_COMPRESSED :
                                                     id3p_pkg::ST_OK);
                                            end
                                        end
                                        if ({29'd0, extras} > len) begin
                                            fail_now = 1'b1;
                                            fcode = id3p_pkg::ST_ERR_FRAME_TRUNC;
                                        end else begin
                                            n_flags = fl[15:0];
                                            n_fstatus = st;
                                            n_extras = extras;
                                            n_funsync = fun;
                                            n_fprev_ff = 1'b0;
                                            n_pcount = '0;
                                            n_fleft = len & 32'(LenMask);
                                            n_payoff = n_bpos;
                                            n_hcount = '0;
                                            if (n_fleft == 0) begin
                                                n_phase = PH_FHDR;
                                                emit = 1'b1;
                                                res.status = st;
                                                res.frame_id = n_id;
                                                res.frame_flags = fl[15:0];
                                                res.payload_offset = n_bpos;
                                            end else begin
                                                n_phase = PH_FBODY;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        PH_FBODY: begin
                            n_fleft = (r_fleft - 32'd1) & 32'(LenMask);
                            if (r_extras != 0) begin
                                n_extras = r_extras - 3'd1;
                                if (r_extras == 3'd1) n_payoff = n_bpos;
                            end else if (r_funsync && r_fprev_ff && b == 8'h00) begin
                                n_fprev_ff = 1'b0;
                            end else begin
                                n_pcount = (r_pcount + 32'd1) & 32'(LenMask);
                                n_fprev_ff = (b == 8'hff);
                            end
                            if (n_fleft == 0) begin
                                n_phase = PH_FHDR; n_hcount = '0;
                                emit = 1'b1;
                                res.status = r_fstatus;
                                res.frame_id = r_id;
                                res.frame_flags = r_flags;
                                res.payload_offset = n_payoff;
                                res.payload_length = n_pcount;
                            end
                        end
                        default: ;
                    endcase
                end
                if (!fail_now && n_phase != PH_IDLE && tl_dec == 0) begin
                    fin = 1'b1;
                    have = emit;
                end
            end

            // Close the region when the tag bytes run out.
            if (fin) begin
                priority case (n_phase)
                    PH_FHDR, PH_PAD: begin
                        if (n_phase == PH_FHDR && n_hcount != 0) begin
                            fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_FHDR_TRUNC;
                        end else begin
                            n_hcount = '0;
                            if (n_footer) begin
                                n_phase = PH_FOOT;
                            end else begin
                                n_phase = PH_IDLE;
                                if (!have) begin
                                    emit = 1'b1;
                                    res = '0;
                                    res.status = id3p_pkg::ST_TAG_END;
                                    res.payload_offset = n_bpos;
                                end
                            end
                        end
                    end
                    PH_FBODY: begin
                        fail_now = !have; fcode = id3p_pkg::ST_ERR_FRAME_TRUNC;
                        if (have) n_phase = PH_IDLE;
                    end
                    PH_EXTLEN, PH_EXTSKIP: begin
                        fail_now = 1'b1; fcode = id3p_pkg::ST_ERR_EXT_HDR;
                    end
                    default: ;
                endcase
            end

            if (fail_now) begin
                n_phase = PH_IDLE;
                emit = 1'b1;
                res = '0;
                res.status = fcode;
                res.payload_offset = n_bpos;
            end
            if (i_item.source_end && n_phase != PH_IDLE) begin
                n_phase = PH_IDLE;
                emit = 1'b1;
                res = '0;
                res.status = id3p_pkg::ST_ERR_SOURCE_END;
                res.payload_offset = n_bpos;
            end
            res.tag_version = n_version;
        end
    end

    assign o_push   = emit;
    assign o_result = res;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_hcount <= '0; r_version <= '0;
            r_tag_left <= '0; r_fleft <= '0; r_pcount <= '0; r_bpos <= '0;
            r_prev_ff <= 1'b0; r_footer <= 1'b0; r_unsync <= 1'b0; r_extras <= '0;
            r_funsync <= 1'b0; r_fprev_ff <= 1'b0; r_fstatus <= '0; r_id <= '0;
            r_flags <= '0; r_payoff <= '0;
        end else begin
            r_phase <= n_phase; r_hcount <= n_hcount; r_version <= n_version;
            r_tag_left <= n_tag_left; r_fleft <= n_fleft;
            r_pcount <= n_pcount; r_bpos <= n_bpos; r_prev_ff <= n_prev_ff;
            r_footer <= n_footer; r_unsync <= n_unsync; r_extras <= n_extras;
            r_funsync <= n_funsync; r_fprev_ff <= n_fprev_ff; r_fstatus <= n_fstatus;
            r_id <= n_id; r_flags <= n_flags; r_payoff <= n_payoff;
        end
    end

    // Header byte buffer, undefined until written.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_hdr[wr_idx] <= b;
    end
endmodule

// ===== hw/rtl/id3p_back.sv =====
// Result back end: pops the queue and drives the output channel register.
module id3p_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  id3p_pkg::t_out_item i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [3:0]          o_status,
    output logic [31:0]         o_frame_id,
    output logic [15:0]         o_frame_flags,
    output logic [31:0]         o_payload_offset,
    output logic [31:0]         o_payload_length,
    output logic [7:0]          o_tag_version
);
    logic                r_valid;
    id3p_pkg::t_out_item r_item;

    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_status = r_item.status;
    assign o_frame_id = r_item.frame_id;
    assign o_frame_flags = r_item.frame_flags;
    assign o_payload_offset = r_item.payload_offset;
    assign o_payload_length = r_item.payload_length;
    assign o_tag_version = r_item.tag_version;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_item <= i_item;
    end
endmodule

// ===== hw/rtl/id3p_checker.sv =====
// Port-level checker for the ID3v2 frame parser, bound to the top level.
`include "assert_macros.svh"
module id3p_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic [3:0] out_status
);
    `ASSERT_IMPL(a_status_range, i_clk, i_rst_n, out_valid, out_status <= 4'd14, "bad status")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid, "valid dropped")
    `ASSERT_NEXT(a_status_stable, i_clk, i_rst_n, out_valid && !out_ready, $stable(out_status), "status changed while stalled")
    `ASSERT_NEXT(a_reset_idle, i_clk, 1'b1, !i_rst_n, !out_valid, "valid after reset")
endmodule

bind id3v2_frame_parser id3p_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.payload.status)
);
